// File: src/usg_pkg.sv
// Shared types, constants and arithmetic helpers of the UV sphere vertex generator.
// No dependencies; every other file but the checker imports this package.
`default_nettype none

package usg_pkg;

  localparam int CordicSteps = 16;
  localparam int CordicDepth = CordicSteps + 1;
  localparam int DivW        = 45;
  localparam int CordW       = 33;
  localparam logic signed [CordW-1:0] CordicX0 = 33'sd652032874;

  localparam logic [2:0] RegUDiv   = 3'd0;
  localparam logic [2:0] RegVDiv   = 3'd1;
  localparam logic [2:0] RegUSpan  = 3'd2;
  localparam logic [2:0] RegVSpan  = 3'd3;
  localparam logic [2:0] RegRadius = 3'd4;

  localparam logic [1:0] Quad0 = 2'd0;
  localparam logic [1:0] Quad1 = 2'd1;
  localparam logic [1:0] Quad2 = 2'd2;
  localparam logic [1:0] Quad3 = 2'd3;

  typedef struct packed {
    logic [7:0]  usub;
    logic [7:0]  vsub;
    logic [15:0] u_span;
    logic [15:0] v_span;
    logic [15:0] radius;
  } cfg_t;

  typedef struct packed {
    logic [24:0] prod_u;
    logic [24:0] prod_v;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [15:0] quad_base;
    logic        quad_valid;
  } item_t;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_z;
  } vert_t;

  function automatic logic signed [CordW-1:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      default: v = 32'h0000517D;
    endcase
    return signed'({1'b0, v});
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    t = (v + 33'sd32768) >>> 16;
    if (t < -33'sd16384) begin
      return -16'sd16384;
    end else if (t > 33'sd16384) begin
      return 16'sd16384;
    end
    return t[15:0];
  endfunction

endpackage

`default_nettype wire

// File: src/usg_front.sv
// Front end: classifies a grid point into the products and quad data the back end needs.
// Depends on usg_pkg.
`default_nettype none

module usg_front import usg_pkg::*; (
  input  wire logic [8:0] col_i,
  input  wire logic [8:0] row_i,
  input  wire cfg_t       cfg_i,
  output item_t           item_o
);

  logic        inside_grid;
  logic [18:0] base_full;

  assign inside_grid = ({1'b0, col_i} < {2'b0, cfg_i.usub}) &&
                       ({1'b0, row_i} < {2'b0, cfg_i.vsub});
  assign base_full   = 19'(18'(col_i) * (18'(cfg_i.vsub) + 18'd1)) + 19'(row_i);

  always_comb begin
    item_o            = '0;
    item_o.prod_u     = 25'(col_i) * 25'(cfg_i.u_span);
    item_o.prod_v     = 25'(row_i) * 25'(cfg_i.v_span);
    item_o.col        = col_i;
    item_o.row        = row_i;
    item_o.quad_valid = inside_grid;
    item_o.quad_base  = inside_grid ? base_full[15:0] : 16'd0;
  end

endmodule

`default_nettype wire

// File: src/usg_fifo.sv
// Short register queue that decouples the front end from the back end.
// Depends on usg_pkg.
`default_nettype none

module usg_fifo import usg_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/usg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on usg_pkg.
`default_nettype none

module usg_div import usg_pkg::*; #(
  parameter int NumW = 45,
  parameter int DenW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            ce_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [NumW];
  logic [DenW-1:0] rem_d [NumW];
  logic [NumW-1:0] wrd_q [NumW];
  logic [NumW-1:0] wrd_d [NumW];

  always_comb begin
    logic [DenW:0]   t;
    logic [DenW-1:0] rin;
    logic [NumW-1:0] win;
    for (int k = 0; k < NumW; k++) begin
      if (k == 0) begin
        rin = '0;
        win = num_i;
      end else begin
        rin = rem_q[k-1];
        win = wrd_q[k-1];
      end
      t = {rin, win[NumW-1]};
      if (t >= {1'b0, den_i}) begin
        rem_d[k] = DenW'(t - {1'b0, den_i});
        wrd_d[k] = {win[NumW-2:0], 1'b1};
      end else begin
        rem_d[k] = t[DenW-1:0];
        wrd_d[k] = {win[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int k = 0; k < NumW; k++) begin
        rem_q[k] <= rem_d[k];
        wrd_q[k] <= wrd_d[k];
      end
    end
  end

  assign quo_o = wrd_q[NumW-1];

endmodule

`default_nettype wire

// File: src/usg_cordic.sv
// Pipelined rotation CORDIC giving sine and cosine in Q1.14 of a 32-bit turn phase.
// Depends on usg_pkg.
`default_nettype none

module usg_cordic import usg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               ce_i,
  input  wire logic [31:0]        phase_i,
  output logic signed [15:0]      sin_o,
  output logic signed [15:0]      cos_o
);

  logic signed [CordW-1:0] x_q [CordicSteps];
  logic signed [CordW-1:0] y_q [CordicSteps];
  logic signed [CordW-1:0] z_q [CordicSteps];
  logic [1:0]              qd_q [CordicSteps];
  logic signed [CordW-1:0] x_d [CordicSteps];
  logic signed [CordW-1:0] y_d [CordicSteps];
  logic signed [CordW-1:0] z_d [CordicSteps];
  logic signed [15:0]      s, c, sin_d, cos_d;
  logic signed [15:0]      sin_q, cos_q;

  always_comb begin
    logic signed [CordW-1:0] xi, yi, zi;
    for (int k = 0; k < CordicSteps; k++) begin
      if (k == 0) begin
        xi = CordicX0;
        yi = '0;
        zi = signed'({3'b000, phase_i[29:0]});
      end else begin
        xi = x_q[k-1];
        yi = y_q[k-1];
        zi = z_q[k-1];
      end
      if (zi >= 0) begin
        x_d[k] = xi - (yi >>> k);
        y_d[k] = yi + (xi >>> k);
        z_d[k] = zi - atan_turn(k);
      end else begin
        x_d[k] = xi + (yi >>> k);
        y_d[k] = yi - (xi >>> k);
        z_d[k] = zi + atan_turn(k);
      end
    end
  end

  assign s = to_q14(y_q[CordicSteps-1]);
  assign c = to_q14(x_q[CordicSteps-1]);

  always_comb begin
    case (qd_q[CordicSteps-1])
      Quad0: begin
        sin_d = s;
        cos_d = c;
      end
      Quad1: begin
        sin_d = c;
        cos_d = -s;
      end
      Quad2: begin
        sin_d = -s;
        cos_d = -c;
      end
      default: begin
        sin_d = -c;
        cos_d = s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int k = 0; k < CordicSteps; k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
        qd_q[k] <= (k == 0) ? phase_i[31:30] : qd_q[(k == 0) ? 0 : k-1];
      end
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

// File: src/usg_back.sv
// Back end: angle and texture division, CORDIC, normal products and positions.
// Depends on usg_pkg, usg_div and usg_cordic.
`default_nettype none

module usg_back import usg_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output vert_t      vert_o,
  output logic [15:0] tex_u_o,
  output logic [15:0] tex_v_o,
  output logic [15:0] quad_base_o,
  output logic        quad_valid_o
);

  localparam int NStg = DivW + CordicDepth + 2;
  localparam int TexN = NStg - DivW;

  logic             ce, load;
  logic [NStg-1:0]  vld_q;
  logic [15:0]      qb_q [NStg];
  logic [NStg-1:0]  qv_q;
  logic [15:0]      tu_q [TexN];
  logic [15:0]      tv_q [TexN];
  logic [DivW-1:0]  qth, qph, qtu, qtv;
  logic signed [15:0] st, ct, sp, cp;
  logic signed [15:0] nx_q, ny_q, nz_q, tx_q, tz_q;
  logic signed [31:0] px, pz;
  vert_t            out_q, out_d;

  assign ce         = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = ce;
  assign load       = in_valid_i && ce;

  usg_div #(.NumW(DivW), .DenW(8)) u_div_th (
    .clk_i, .ce_i(ce), .num_i({item_i.prod_u, 20'd0}), .den_i(cfg_i.usub), .quo_o(qth));
  usg_div #(.NumW(DivW), .DenW(8)) u_div_ph (
    .clk_i, .ce_i(ce), .num_i({1'b0, item_i.prod_v, 19'd0}), .den_i(cfg_i.vsub),
    .quo_o(qph));
  usg_div #(.NumW(DivW), .DenW(8)) u_div_tu (
    .clk_i, .ce_i(ce), .num_i({21'd0, item_i.col, 15'd0}), .den_i(cfg_i.usub),
    .quo_o(qtu));
  usg_div #(.NumW(DivW), .DenW(8)) u_div_tv (
    .clk_i, .ce_i(ce), .num_i({21'd0, item_i.row, 15'd0}), .den_i(cfg_i.vsub),
    .quo_o(qtv));

  usg_cordic u_cor_th (.clk_i, .ce_i(ce), .phase_i(qth[31:0]), .sin_o(st), .cos_o(ct));
  usg_cordic u_cor_ph (.clk_i, .ce_i(ce), .phase_i(qph[31:0]), .sin_o(sp), .cos_o(cp));

  assign px = st * sp + 32'sd8192;
  assign pz = ct * sp + 32'sd8192;

  function automatic logic signed [16:0] pos_of(input logic [15:0] r,
                                                 input logic signed [15:0] n);
    logic signed [33:0] p;
    p = (signed'({1'b0, r}) * n + 34'sd8192) >>> 14;
    if (p < -34'sd65536) begin
      return -17'sd65536;
    end else if (p > 34'sd65535) begin
      return 17'sd65535;
    end
    return p[16:0];
  endfunction

  always_comb begin
    out_d       = '0;
    out_d.pos_x = pos_of(cfg_i.radius, nx_q);
    out_d.pos_y = pos_of(cfg_i.radius, ny_q);
    out_d.pos_z = pos_of(cfg_i.radius, nz_q);
    out_d.nrm_x = nx_q;
    out_d.nrm_y = ny_q;
    out_d.nrm_z = nz_q;
    out_d.tan_x = tx_q;
    out_d.tan_z = tz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NStg-2:0], load};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      qb_q[0] <= item_i.quad_base;
      qv_q    <= {qv_q[NStg-2:0], item_i.quad_valid};
      for (int k = 1; k < NStg; k++) begin
        qb_q[k] <= qb_q[k-1];
      end
      tu_q[0] <= (qtu > DivW'(32768)) ? 16'd32768 : qtu[15:0];
      tv_q[0] <= (qtv > DivW'(32768)) ? 16'd32768 : qtv[15:0];
      for (int k = 1; k < TexN; k++) begin
        tu_q[k] <= tu_q[k-1];
        tv_q[k] <= tv_q[k-1];
      end
      nx_q  <= 16'(px >>> 14);
      ny_q  <= cp;
      nz_q  <= 16'(pz >>> 14);
      tx_q  <= ct;
      tz_q  <= -st;
      out_q <= out_d;
    end
  end

  assign out_valid_o  = vld_q[NStg-1];
  assign vert_o       = out_q;
  assign tex_u_o      = tu_q[TexN-1];
  assign tex_v_o      = tv_q[TexN-1];
  assign quad_base_o  = qb_q[NStg-1];
  assign quad_valid_o = qv_q[NStg-1];

endmodule

`default_nettype wire

// File: src/uv_sphere_vertex_generator.sv
// Throughput: one vertex per cycle while the output is not stalled; the 45-stage divider,
// the 17-stage CORDIC and two arithmetic stages all advance together, behind a four-beat input queue.
// Reset clears the queue, the stage valid bits and the configuration registers to their defaults.
// Depends on usg_pkg, usg_front, usg_fifo and usg_back.
`default_nettype none

module uv_sphere_vertex_generator import usg_pkg::*; #(
  parameter int MAX_SUB = 255
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // col_index[8:0], row_index[17:9], zero pad
  input  wire logic [23:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x[16:0], pos_y[33:17], pos_z[50:34], nrm_x[66:51], nrm_y[82:67],
  // nrm_z[98:83], tan_x[114:99], tan_z[130:115], tex_u[146:131],
  // tex_v[162:147], quad_base[178:163], quad_valid[179], zero pad
  output logic [183:0]      m_axis_tdata
);

  localparam logic [9:0] MaxSub = 10'(MAX_SUB);

  logic [7:0]  udiv_q, vdiv_q;
  logic [15:0] uspan_q, vspan_q, rad_q;
  logic [9:0]  ulo, vlo;
  cfg_t        cfg;
  item_t       f_item, q_item;
  logic        q_full, q_valid, b_ready, push;
  vert_t       vert;
  logic [15:0] tex_u, tex_v, qbase;
  logic        qvalid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udiv_q  <= 8'd16;
      vdiv_q  <= 8'd8;
      uspan_q <= 16'd4096;
      vspan_q <= 16'd4096;
      rad_q   <= 16'd256;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegUDiv:   udiv_q  <= cfg_data_i[7:0];
        RegVDiv:   vdiv_q  <= cfg_data_i[7:0];
        RegUSpan:  uspan_q <= cfg_data_i;
        RegVSpan:  vspan_q <= cfg_data_i;
        RegRadius: rad_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ulo = (udiv_q < 8'd4) ? 10'd4 : {2'b00, udiv_q};
  assign vlo = (vdiv_q < 8'd2) ? 10'd2 : {2'b00, vdiv_q};

  always_comb begin
    cfg        = '0;
    cfg.usub   = (ulo > MaxSub) ? MaxSub[7:0] : ulo[7:0];
    cfg.vsub   = (vlo > MaxSub) ? MaxSub[7:0] : vlo[7:0];
    cfg.u_span = uspan_q;
    cfg.v_span = vspan_q;
    cfg.radius = rad_q;
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  usg_front u_front (
    .col_i  (s_axis_tdata[8:0]),
    .row_i  (s_axis_tdata[17:9]),
    .cfg_i  (cfg),
    .item_o (f_item)
  );

  usg_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_valid && b_ready),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  usg_back u_back (
    .clk_i, .rst_ni,
    .cfg_i        (cfg),
    .in_valid_i   (q_valid),
    .in_ready_o   (b_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .vert_o       (vert),
    .tex_u_o      (tex_u),
    .tex_v_o      (tex_v),
    .quad_base_o  (qbase),
    .quad_valid_o (qvalid)
  );

  assign m_axis_tdata = {4'd0, qvalid, qbase, tex_v, tex_u, vert.tan_z, vert.tan_x,
                         vert.nrm_z, vert.nrm_y, vert.nrm_x, vert.pos_z, vert.pos_y,
                         vert.pos_x};

endmodule

`default_nettype wire

// File: src/usg_checker.sv
// Port-level checker of the UV sphere vertex generator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module usg_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [183:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[179] |-> m_axis_tdata[178:163] == 16'd0)
    else $error("quad base set without a quad");

  a_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[179] |->
      m_axis_tdata[146] == 1'b0 && m_axis_tdata[162] == 1'b0)
    else $error("texture coordinate of a quad corner reached one");

  a_nrm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[82:67]) <= 16'sd16384 &&
                      $signed(m_axis_tdata[82:67]) >= -16'sd16384)
    else $error("normal y out of unit range");

endmodule

bind uv_sphere_vertex_generator usg_checker u_usg_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

`default_nettype wire

// File: tb/uv_sphere_vertex_generator_tb.sv
// Self-checking testbench for the UV sphere vertex generator: drives grid points
// through the stream input, predicts each vertex and compares it field by field.
// Depends on usg_pkg and the uv_sphere_vertex_generator RTL.
`default_nettype none

module uv_sphere_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import usg_pkg::*;

  localparam int SubLimit = 255;
  localparam int Latency  = 65;
  localparam int Limit    = 400000;
  localparam logic [2:0] RegUnused = 3'd7;

  typedef struct packed {
    logic        quad_valid;
    logic [15:0] quad_base, tex_v, tex_u, tan_z, tan_x, nrm_z, nrm_y, nrm_x;
    logic [16:0] pos_z, pos_y, pos_x;
  } vertex_t;

  typedef struct {
    int col;
    int row;
    bit known;
    int nrm_x, nrm_y, nrm_z, tex_u, tex_v, quad_valid;
  } row_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [2:0] cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [183:0] m_axis_tdata;

  uv_sphere_vertex_generator i_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  int u_div = 16, v_div = 8, u_span_r = 4096, v_span_r = 4096, radius_r = 256;
  vertex_t vertex_q[$];
  row_t known_q[$];
  int errors = 0;
  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q14_of(longint v);
    return clampl(fshift(v + 32768, 16), -16384, 16384);
  endfunction

  function automatic longint atan_step(int i);
    longint t[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    return t[i];
  endfunction

  function automatic void rotate(input logic [31:0] phase, output longint sn,
                                 output longint cs);
    longint x, y, z, dx, dy, s, c;
    x = 652032874; y = 0; z = phase[29:0];
    for (int i = 0; i < 16; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    s = q14_of(y); c = q14_of(x);
    case (phase[31:30])
      Quad0: begin sn = s; cs = c; end
      Quad1: begin sn = c; cs = -s; end
      Quad2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic [16:0] scaled_pos(longint n);
    return 17'(clampl(fshift(longint'(radius_r) * n + 8192, 14), -65536, 65535));
  endfunction

  function automatic longint clamp_div(int v, int lo);
    return v < lo ? lo : (v > SubLimit ? SubLimit : v);
  endfunction

  function automatic vertex_t predict_vertex(int col, int row);
    vertex_t r;
    longint usub, vsub, st, ct, sp, cp, nx, ny, nz, tu, tv;
    logic [31:0] th, ph;
    bit ok;
    usub = clamp_div(u_div, 4); vsub = clamp_div(v_div, 2);
    th = 32'(((longint'(col) * u_span_r) <<< 20) / usub);
    ph = 32'(((longint'(row) * v_span_r) <<< 19) / vsub);
    rotate(th, st, ct);
    rotate(ph, sp, cp);
    nx = fshift(st * sp + 8192, 14); ny = cp; nz = fshift(ct * sp + 8192, 14);
    ok = col < usub && row < vsub;
    tu = (longint'(col) * 32768) / usub; tv = (longint'(row) * 32768) / vsub;
    r.pos_x = scaled_pos(nx); r.pos_y = scaled_pos(ny); r.pos_z = scaled_pos(nz);
    r.nrm_x = 16'(nx); r.nrm_y = 16'(ny); r.nrm_z = 16'(nz);
    r.tan_x = 16'(ct); r.tan_z = 16'(-st);
    r.tex_u = tu > 32768 ? 16'd32768 : 16'(tu);
    r.tex_v = tv > 32768 ? 16'd32768 : 16'(tv);
    r.quad_base = ok ? 16'(longint'(col) * (vsub + 1) + row) : 16'd0;
    r.quad_valid = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Result side: compare each beat against the oldest expectation, and apply random back-pressure.
  int stall_left = 0;
  always @(posedge clk_i) begin
    vertex_t got, want;
    row_t k;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[179:0];
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = vertex_q.pop_front();
          k = known_q.pop_front();
          if (k.known && (k.nrm_x != 32'(signed'(want.nrm_x)) ||
              k.nrm_y != 32'(signed'(want.nrm_y)) || k.nrm_z != 32'(signed'(want.nrm_z)) ||
              k.tex_u != want.tex_u || k.tex_v != want.tex_v ||
              k.quad_valid != want.quad_valid))
            report_mismatch("table row", 0, 0);
          if (got.pos_x != want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
          if (got.pos_y != want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
          if (got.pos_z != want.pos_z) report_mismatch("pos_z", got.pos_z, want.pos_z);
          if (got.nrm_x != want.nrm_x) report_mismatch("nrm_x", got.nrm_x, want.nrm_x);
          if (got.nrm_y != want.nrm_y) report_mismatch("nrm_y", got.nrm_y, want.nrm_y);
          if (got.nrm_z != want.nrm_z) report_mismatch("nrm_z", got.nrm_z, want.nrm_z);
          if (got.tan_x != want.tan_x) report_mismatch("tan_x", got.tan_x, want.tan_x);
          if (got.tan_z != want.tan_z) report_mismatch("tan_z", got.tan_z, want.tan_z);
          if (got.tex_u != want.tex_u) report_mismatch("tex_u", got.tex_u, want.tex_u);
          if (got.tex_v != want.tex_v) report_mismatch("tex_v", got.tex_v, want.tex_v);
          if (got.quad_base != want.quad_base)
            report_mismatch("quad_base", got.quad_base, want.quad_base);
          if (got.quad_valid != want.quad_valid)
            report_mismatch("quad_valid", got.quad_valid, want.quad_valid);
        end
      end
      if (m_axis_tready && !m_axis_tvalid) begin
        // hold ready while waiting for a beat
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        if ($urandom_range(3) == 0) begin
          stall_left <= $urandom_range(6);
          m_axis_tready <= 0;
        end
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int value);
    @(posedge clk_i);
    cfg_valid_i <= 1; cfg_addr_i <= idx; cfg_data_i <= 16'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      RegUDiv:   u_div = value & 8'hFF;
      RegVDiv:   v_div = value & 8'hFF;
      RegUSpan:  u_span_r = value & 16'hFFFF;
      RegVSpan:  v_span_r = value & 16'hFFFF;
      RegRadius: radius_r = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic send_point(input row_t r, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    vertex_q.push_back(predict_vertex(r.col, r.row));
    known_q.push_back(r);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, 9'(r.row), 9'(r.col)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic row_t plain(int c, int r);
    row_t t;
    t.col = c; t.row = r; t.known = 0;
    return t;
  endfunction

  function automatic row_t fixed(int c, int r, int nx, int ny, int nz, int tu, int tv, int qv);
    row_t t;
    t.col = c; t.row = r; t.known = 1;
    t.nrm_x = nx; t.nrm_y = ny; t.nrm_z = nz; t.tex_u = tu; t.tex_v = tv; t.quad_valid = qv;
    return t;
  endfunction

  initial begin
    row_t table_rows[$];
    int cfgs[5][5] = '{'{16, 8, 4096, 4096, 256}, '{0, 0, 1, 1, 0},
                       '{255, 255, 65535, 65535, 65535}, '{4, 2, 4096, 2048, 1},
                       '{37, 19, 4096, 4096, 12800}};
    int usub, vsub;
    // At the north pole with the reset settings the normal is straight up.
    table_rows.push_back(fixed(0, 0, 0, 16384, 0, 0, 0, 1));
    table_rows.push_back(fixed(16, 8, 0, -16384, 0, 32768, 32768, 0));
    table_rows.push_back(plain(511, 511));
    table_rows.push_back(plain(15, 7));
    table_rows.push_back(plain(4, 4));
    table_rows.push_back(plain(8, 2));
    table_rows.push_back(plain(12, 6));
    table_rows.push_back(plain(256, 256));
    table_rows.push_back(plain(0, 8));
    table_rows.push_back(plain(16, 0));
    table_rows.push_back(plain(170, 341));
    table_rows.push_back(plain(341, 170));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (table_rows[i]) begin
      send_point(table_rows[i], 1);
    end
    drain();
    write_reg(RegUnused, 123);
    for (int p = 0; p < 5; p++) begin
      for (int r = 0; r < 5; r++) write_reg(3'(r), cfgs[p][r]);
      send_point(plain(0, 0), 0);
      send_point(plain(511, 511), 0);
      send_point(plain(1, 1), 0);
      drain();
    end
    for (int n = 0; n < 1850; n++) begin
      if (n % 370 == 0) begin
        drain();
        write_reg(RegUDiv, $urandom_range(n == 0 ? 3 : 255));
        write_reg(RegVDiv, $urandom_range(255));
        write_reg(RegUSpan, $urandom_range(65535, 1));
        write_reg(RegVSpan, $urandom_range(65535, 1));
        write_reg(RegRadius, $urandom_range(65535));
      end
      usub = clamp_div(u_div, 4); vsub = clamp_div(v_div, 2);
      if ($urandom_range(9) == 0)
        send_point(plain($urandom_range(511), $urandom_range(511)), n % 200 > 60);
      else
        send_point(plain($urandom_range(usub), $urandom_range(vsub)), n % 200 > 60);
    end
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
src/usg_pkg.sv
src/usg_front.sv
src/usg_fifo.sv
src/usg_div.sv
src/usg_cordic.sv
src/usg_back.sv
src/uv_sphere_vertex_generator.sv
src/usg_checker.sv
tb/uv_sphere_vertex_generator_tb.sv
